/* hw/rtl/tws_pkg.sv */
// Package for the tile window streamer: sizes, window types and the job descriptor.
// Used by the front, queue, back and top level modules. Depends on nothing else.
package tws_pkg;

    localparam int VIEW_WIDTH   = 240;
    localparam int VIEW_HEIGHT  = 160;
    localparam int BUFFER_TILES = 32;
    localparam int TILE_SHIFT   = 3;
    localparam int MAX_RUNS     = 64;

    localparam int CAM_W   = 15;
    localparam int COORD_W = 14;
    localparam int DIFF_W  = COORD_W + 1;
    localparam int SUM_W   = COORD_W + 2;
    localparam int CNT_W   = $clog2(MAX_RUNS + 1);
    localparam int Q_DEPTH = 2;
    localparam int QPTR_W  = $clog2(Q_DEPTH);

    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 48;

    typedef logic [CAM_W-1:0]          cam_t;
    typedef logic signed [COORD_W-1:0] coord_t;
    typedef logic signed [DIFF_W-1:0]  diff_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic [CNT_W-1:0]          cnt_t;

    typedef struct packed {
        coord_t lo;
        coord_t hi;
    } seg_t;

    // Four line ranges: new left columns, new right columns, new top rows,
    // new bottom rows. A full refill uses the first range only.
    typedef struct packed {
        seg_t [3:0] segs;
        coord_t     col_first;
        coord_t     col_last;
        coord_t     row_first;
        coord_t     row_last;
        cnt_t       total;
    } job_t;

    typedef struct packed {
        logic not_empty;
        logic full;
    } qstat_t;

endpackage

/* hw/rtl/tilemap_window_streamer.sv */
// Top level of the tile window streamer: front, job queue and back part.
// Depends on tws_pkg, tws_front, tws_queue and tws_back.
//
//  Channel   Direction  Handshake                    Payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tdata: cam_x, cam_y
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata: coords, tuser: is_row, tlast
//
// For each item the back part loads a line range, emits its runs in order, steps past
// line ranges that hold no runs and retires the job once all its runs are out; the
// back part's walk sets how long an item takes.
// The front register and the queue lie between an accepted position and the back part.
// The front accepts the next camera position while its register is empty or the queue of two jobs has room.
// Reset clears the synced window to empty, so the first item does a full refill.
// A stalled output holds the current run; the walk waits until the stage frees.
module tilemap_window_streamer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // Bits from 0: cam_x[14:0], cam_y[29:15], zero [31:30].
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // Bits from 0: line_coord[13:0], span_first[27:14], span_last[41:28], zero [47:42].
    output logic [47:0] m_axis_tdata,
    // Bit 0: is_row.
    output logic        m_axis_tuser,
    output logic        m_axis_tlast
);
    import tws_pkg::*;

    logic   push, pop;
    job_t   push_job, head_job;
    qstat_t qstat;
    coord_t line, first, last;

    tws_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .cam_x    (s_axis_tdata[CAM_W-1:0]),
        .cam_y    (s_axis_tdata[2*CAM_W-1:CAM_W]),
        .q_full   (qstat.full),
        .push     (push),
        .push_job (push_job)
    );

    tws_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head_job (head_job),
        .stat     (qstat)
    );

    tws_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .job        (head_job),
        .qstat      (qstat),
        .pop        (pop),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_is_row (m_axis_tuser),
        .out_line   (line),
        .out_first  (first),
        .out_last   (last),
        .out_final  (m_axis_tlast)
    );

    assign m_axis_tdata = {6'b0, last, first, line};

endmodule

/* hw/rtl/tws_front.sv */
// Front part: accepts camera positions, computes the tile window and classifies
// the update into a run job. Holds the synced window. Depends on tws_pkg.
module tws_front (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  tws_pkg::cam_t   cam_x,
    input  tws_pkg::cam_t   cam_y,
    input  logic            q_full,
    output logic            push,
    output tws_pkg::job_t   push_job
);
    import tws_pkg::*;

    function automatic diff_t gain(coord_t a, coord_t b);
        diff_t d;
        d = diff_t'(a) - diff_t'(b);
        return (d > diff_t'(0)) ? d : diff_t'(0);
    endfunction

    logic   s1_valid_reg, s1_valid_next;
    coord_t nl_reg, nr_reg, nt_reg, nb_reg;
    coord_t nl_next, nr_next, nt_next, nb_next;
    coord_t wl_reg, wr_reg, wt_reg, wb_reg;
    coord_t wl_next, wr_next, wt_next, wb_next;

    logic [CAM_W:0] x_far, y_far;
    logic           accept;
    diff_t          gl, gr, gt, gb;
    sum_t           cols, rows, raw_total;
    logic           full;

    assign in_ready = !s1_valid_reg || !q_full;
    assign accept   = in_valid && in_ready;
    assign push     = s1_valid_reg && !q_full;

    assign x_far = {1'b0, cam_x} + (CAM_W+1)'(VIEW_WIDTH - 1);
    assign y_far = {1'b0, cam_y} + (CAM_W+1)'(VIEW_HEIGHT - 1);

    assign gl   = gain(wl_reg, nl_reg);
    assign gr   = gain(nr_reg, wr_reg);
    assign gt   = gain(wt_reg, nt_reg);
    assign gb   = gain(nb_reg, wb_reg);
    assign cols = sum_t'(gl) + sum_t'(gr);
    assign rows = sum_t'(gt) + sum_t'(gb);
    assign full = (wl_reg > wr_reg) || (cols > sum_t'(BUFFER_TILES))
                  || (rows > sum_t'(BUFFER_TILES));
    assign raw_total = full ? (sum_t'(nr_reg) - sum_t'(nl_reg) + sum_t'(1)) : (cols + rows);

    always_comb
    begin
        push_job.segs[0].lo = nl_reg;
        push_job.segs[0].hi = full ? nr_reg : (wl_reg - coord_t'(1));
        push_job.segs[1].lo = wr_reg + coord_t'(1);
        push_job.segs[1].hi = nr_reg;
        push_job.segs[2].lo = nt_reg;
        push_job.segs[2].hi = wt_reg - coord_t'(1);
        push_job.segs[3].lo = wb_reg + coord_t'(1);
        push_job.segs[3].hi = nb_reg;
        push_job.col_first  = full ? nt_reg : wt_reg;
        push_job.col_last   = full ? nb_reg : wb_reg;
        push_job.row_first  = nl_reg;
        push_job.row_last   = nr_reg;
        push_job.total      = (raw_total > sum_t'(MAX_RUNS)) ? cnt_t'(MAX_RUNS)
                                                               : raw_total[CNT_W-1:0];
    end

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        nl_next = nl_reg;
        nr_next = nr_reg;
        nt_next = nt_reg;
        nb_next = nb_reg;
        wl_next = wl_reg;
        wr_next = wr_reg;
        wt_next = wt_reg;
        wb_next = wb_reg;
        if (push)
        begin
            s1_valid_next = 1'b0;
            wl_next = nl_reg;
            wr_next = nr_reg;
            wt_next = nt_reg;
            wb_next = nb_reg;
        end
        if (accept)
        begin
            s1_valid_next = 1'b1;
            nl_next = coord_t'(cam_x >> TILE_SHIFT) - coord_t'(1);
            nr_next = coord_t'(x_far >> TILE_SHIFT) + coord_t'(1);
            nt_next = coord_t'(cam_y >> TILE_SHIFT) - coord_t'(1);
            nb_next = coord_t'(y_far >> TILE_SHIFT) + coord_t'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            nl_reg <= '0;
            nr_reg <= '0;
            nt_reg <= '0;
            nb_reg <= '0;
            wl_reg <= coord_t'(1);
            wr_reg <= coord_t'(0);
            wt_reg <= coord_t'(1);
            wb_reg <= coord_t'(0);
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            nl_reg <= nl_next;
            nr_reg <= nr_next;
            nt_reg <= nt_next;
            nb_reg <= nb_next;
            wl_reg <= wl_next;
            wr_reg <= wr_next;
            wt_reg <= wt_next;
            wb_reg <= wb_next;
        end
    end

endmodule

/* hw/rtl/tws_queue.sv */
// Short job queue between the front and back parts of the tile window streamer.
// Two register entries. Depends on tws_pkg.
module tws_queue (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  tws_pkg::job_t   push_job,
    input  logic            pop,
    output tws_pkg::job_t   head_job,
    output tws_pkg::qstat_t stat
);
    import tws_pkg::*;

    job_t                  entry_reg [Q_DEPTH];
    logic [QPTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [QPTR_W:0]       count_reg;

    assign head_job       = entry_reg[rd_ptr_reg];
    assign stat.not_empty = (count_reg != '0);
    assign stat.full      = (count_reg == (QPTR_W+1)'(Q_DEPTH));

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_reg + (QPTR_W+1)'(push) - (QPTR_W+1)'(pop);
        end
    end

endmodule

/* hw/rtl/tws_back.sv */
// Back part: walks the line ranges of the head job and emits one run per cycle, while
// the registered output stage has room. Depends on tws_pkg.
module tws_back (
    input  logic            clk,
    input  logic            rst_n,
    input  tws_pkg::job_t   job,
    input  tws_pkg::qstat_t qstat,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic            out_is_row,
    output tws_pkg::coord_t out_line,
    output tws_pkg::coord_t out_first,
    output tws_pkg::coord_t out_last,
    output logic            out_final
);
    import tws_pkg::*;

    typedef enum logic {ST_LOAD, ST_RUN} state_t;

    state_t      state_reg, state_next;
    logic [1:0]  seg_idx_reg, seg_idx_next;
    coord_t      cur_reg, cur_next;
    cnt_t        emitted_reg, emitted_next;
    logic        valid_reg, valid_next;
    logic        is_row_reg, is_row_next;
    coord_t      line_reg, line_next;
    coord_t      first_reg, first_next;
    coord_t      last_reg, last_next;
    logic        final_reg, final_next;

    seg_t        seg;
    logic        slot_free;
    logic        emit;

    always_comb
    begin
        case (seg_idx_reg)
            2'd0:    seg = job.segs[0];
            2'd1:    seg = job.segs[1];
            2'd2:    seg = job.segs[2];
            default: seg = job.segs[3];
        endcase
    end

    assign slot_free = !valid_reg || out_ready;
    assign emit = qstat.not_empty && (state_reg == ST_RUN) && (emitted_reg != job.total)
                  && !(cur_reg > seg.hi) && slot_free;
    assign pop  = qstat.not_empty && (state_reg == ST_RUN) && (emitted_reg == job.total);

    always_comb
    begin
        state_next   = state_reg;
        seg_idx_next = seg_idx_reg;
        cur_next     = cur_reg;
        emitted_next = emitted_reg;
        valid_next   = valid_reg && !out_ready;
        is_row_next  = is_row_reg;
        line_next    = line_reg;
        first_next   = first_reg;
        last_next    = last_reg;
        final_next   = final_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (qstat.not_empty)
                begin
                    cur_next   = seg.lo;
                    state_next = ST_RUN;
                end
            end
            ST_RUN:
            begin
                if (pop)
                begin
                    emitted_next = '0;
                    seg_idx_next = '0;
                    state_next   = ST_LOAD;
                end
                else if (qstat.not_empty && (cur_reg > seg.hi))
                begin
                    seg_idx_next = seg_idx_reg + 2'd1;
                    state_next   = ST_LOAD;
                end
                else if (emit)
                begin
                    cur_next     = cur_reg + coord_t'(1);
                    emitted_next = emitted_reg + cnt_t'(1);
                    valid_next   = 1'b1;
                    is_row_next  = seg_idx_reg[1];
                    line_next    = cur_reg;
                    first_next   = seg_idx_reg[1] ? job.row_first : job.col_first;
                    last_next    = seg_idx_reg[1] ? job.row_last : job.col_last;
                    final_next   = (emitted_reg + cnt_t'(1)) == job.total;
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_LOAD;
            seg_idx_reg <= '0;
            cur_reg     <= '0;
            emitted_reg <= '0;
            valid_reg   <= 1'b0;
            is_row_reg  <= 1'b0;
            line_reg    <= '0;
            first_reg   <= '0;
            last_reg    <= '0;
            final_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            seg_idx_reg <= seg_idx_next;
            cur_reg     <= cur_next;
            emitted_reg <= emitted_next;
            valid_reg   <= valid_next;
            is_row_reg  <= is_row_next;
            line_reg    <= line_next;
            first_reg   <= first_next;
            last_reg    <= last_next;
            final_reg   <= final_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_is_row = is_row_reg;
    assign out_line   = line_reg;
    assign out_first  = first_reg;
    assign out_last   = last_reg;
    assign out_final  = final_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        qstat.not_empty |-> emitted_reg <= job.total)
        else $error("run count passed the job total");

    a_pop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (emitted_reg == '0) && (seg_idx_reg == 2'd0))
        else $error("job retired without clearing the walk");

    a_emit_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        emit |-> (cur_reg <= seg.hi) && (seg_idx_reg == 2'd0 || job.total != cnt_t'(0)))
        else $error("run emitted outside its line range");

    a_final_ends_job: assert property (@(posedge clk) disable iff (!rst_n)
        (emit && ((emitted_reg + cnt_t'(1)) == job.total)) |=> pop || !qstat.not_empty
            || (state_reg == ST_RUN && emitted_reg == job.total))
        else $error("final run not followed by job retirement");

endmodule
